@@ rtl/pipr_pkg.sv @@
// ----------------------------------------------------------------------------
// pipr_pkg
// Shared constants and types of the point-in-polygon ray-cast block.
// ----------------------------------------------------------------------------
package pipr_pkg;

    localparam int MAX_VERTICES = 256;
    localparam int COORD_W      = 16;
    localparam int MIN_VERTICES = 3;

    localparam int ADDR_W = $clog2(MAX_VERTICES);
    localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
    localparam int CFG_W  = 9;
    localparam int IDX_W  = 8;
    localparam int DIFF_W = COORD_W + 1;
    localparam int PROD_W = 2 * DIFF_W;

    localparam int X_LSB     = IDX_W;
    localparam int Y_LSB     = IDX_W + COORD_W;
    localparam int S_TDATA_W = ((IDX_W + 2 * COORD_W + 7) / 8) * 8;
    localparam int M_TDATA_W = 8;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } t_vertex;

    typedef struct packed {
        logic                      vld;
        logic                      last;
        logic signed [COORD_W-1:0] xi;
        logic signed [COORD_W-1:0] yi;
        logic signed [COORD_W-1:0] xj;
        logic signed [COORD_W-1:0] yj;
    } t_edge;

    typedef struct packed {
        logic vld;
        logic last;
        logic hit;
    } t_cross;

endpackage

@@ rtl/point_in_polygon_ray_cast.sv @@
// ----------------------------------------------------------------------------
// point_in_polygon_ray_cast
// Even-odd ray-cast point-in-polygon test over a stored vertex table.
// ----------------------------------------------------------------------------
// Input beats on the slave stream: tuser selects a vertex write or a query;
// tdata carries the vertex index and the x and y coordinates (signed, four
// fraction bits). A write stores one vertex and gives no result.
// A query walks the n vertices in use (i_cfg_wdata written via i_cfg_we,
// capped at the table depth), one vertex read per cycle from the vertex RAM,
// plus the closing edge, through a two-stage cross-product compare.
// After the closing edge leaves the compare, the result goes via S_FIN to the
// output register; the RAM read port sets the pace of one edge per cycle,
// and the input is ready again once the result is loaded. With fewer than
// three vertices the walk is skipped and the result has the flag in tuser set.
// One query is in flight at a time; the next beat is taken once the result
// sits in the output register. A stalled master side holds the result and
// vertex writes are still accepted behind it; a further query completes its
// walk and then waits until the output register is free.
// Reset clears the vertex count and all handshake state; the vertex table
// holds no defined content until written.
// ----------------------------------------------------------------------------
module point_in_polygon_ray_cast (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // vertex_index [7:0], x_coord [23:8], y_coord [39:24]
    input  logic [pipr_pkg::S_TDATA_W-1:0]   i_s_axis_tdata,
    // operation [0]
    input  logic [0:0]                       i_s_axis_tuser,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // inside_res [0], zero [7:1]
    output logic [pipr_pkg::M_TDATA_W-1:0]   o_m_axis_tdata,
    // too_few_vertices [0]
    output logic [0:0]                       o_m_axis_tuser,
    input  logic                             i_cfg_we,
    input  logic [pipr_pkg::CFG_W-1:0]       i_cfg_wdata
);
    import pipr_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0]                r_state;
    logic [1:0]                n_state;
    logic [CFG_W-1:0]          r_vcount;
    logic [CNT_W-1:0]          r_n;
    logic [CNT_W-1:0]          r_rd_addr;
    logic                      r_rd_vld;
    logic                      r_rd_first;
    logic                      r_rd_last;
    logic                      r_close;
    logic                      r_parity;
    logic                      r_res_inside;
    logic                      r_res_few;
    logic                      r_out_vld;
    logic                      r_out_inside;
    logic                      r_out_few;
    logic signed [COORD_W-1:0] r_px;
    logic signed [COORD_W-1:0] r_py;
    t_vertex                   r_v0;
    t_vertex                   r_prev;

    logic                      in_acc;
    logic                      is_query;
    logic [IDX_W-1:0]          in_idx;
    t_vertex                   in_vtx;
    logic [CNT_W-1:0]          sat_n;
    logic                      issue;
    logic                      fin_load;
    logic                      ram_we;
    t_vertex                   rd_vtx;
    t_edge                     e_in;
    t_cross                    e_out;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign is_query        = (i_s_axis_tuser[0] == OP_QUERY);
    assign in_idx          = i_s_axis_tdata[IDX_W-1:0];
    assign in_vtx.x        = $signed(i_s_axis_tdata[X_LSB +: COORD_W]);
    assign in_vtx.y        = $signed(i_s_axis_tdata[Y_LSB +: COORD_W]);

    assign sat_n    = (32'(r_vcount) > MAX_VERTICES) ? CNT_W'(MAX_VERTICES)
                                                     : CNT_W'(r_vcount);
    assign issue    = (r_state == S_RUN) && (r_rd_addr < r_n);
    assign fin_load = (r_state == S_FIN) && (!r_out_vld || i_m_axis_tready);
    assign ram_we   = in_acc && (i_s_axis_tuser[0] == OP_WRITE) &&
                      (32'(in_idx) < MAX_VERTICES);

    pipr_ram #(
        .WIDTH ($bits(t_vertex)),
        .DEPTH (MAX_VERTICES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ADDR_W'(in_idx)),
        .i_wdata (in_vtx),
        .i_raddr (r_rd_addr[ADDR_W-1:0]),
        .o_rdata (rd_vtx)
    );

    always_comb begin
        e_in.vld  = r_close || (r_rd_vld && !r_rd_first);
        e_in.last = r_close;
        e_in.xi   = r_prev.x;
        e_in.yi   = r_prev.y;
        e_in.xj   = r_close ? r_v0.x : rd_vtx.x;
        e_in.yj   = r_close ? r_v0.y : rd_vtx.y;
    end

    pipr_edge u_edge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_px    (r_px),
        .i_py    (r_py),
        .i_edge  (e_in),
        .o_cross (e_out)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && is_query) begin
                    n_state = (32'(sat_n) < MIN_VERTICES) ? S_FIN : S_RUN;
                end
            end
            S_RUN: begin
                if (e_out.vld && e_out.last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (fin_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_vcount  <= '0;
            r_rd_addr <= '0;
            r_rd_vld  <= 1'b0;
            r_close   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= issue;
            r_close  <= r_rd_vld && r_rd_last;
            if (i_cfg_we) begin
                r_vcount <= i_cfg_wdata;
            end
            if (in_acc && is_query) begin
                r_rd_addr <= '0;
            end else if (issue) begin
                r_rd_addr <= r_rd_addr + CNT_W'(1);
            end
            if (fin_load) begin
                r_out_vld <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_first <= (r_rd_addr == '0);
        r_rd_last  <= (r_rd_addr == r_n - CNT_W'(1));
        if (in_acc && is_query) begin
            r_px         <= in_vtx.x;
            r_py         <= in_vtx.y;
            r_n          <= sat_n;
            r_parity     <= 1'b0;
            r_res_inside <= 1'b0;
            r_res_few    <= 1'b1;
        end else if (e_out.vld) begin
            r_parity <= r_parity ^ e_out.hit;
            if (e_out.last) begin
                r_res_inside <= r_parity ^ e_out.hit;
                r_res_few    <= 1'b0;
            end
        end
        if (r_rd_vld) begin
            r_prev <= rd_vtx;
            if (r_rd_first) begin
                r_v0 <= rd_vtx;
            end
        end
        if (fin_load) begin
            r_out_inside <= r_res_inside;
            r_out_few    <= r_res_few;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {{(M_TDATA_W-1){1'b0}}, r_out_inside};
    assign o_m_axis_tuser  = r_out_few;

`ifndef NO_ASSERTIONS
    a_last_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (e_out.vld && e_out.last) |-> (r_state == S_RUN))
        else $error("closing edge result outside a query walk");

    a_fin_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && r_out_vld && !i_m_axis_tready) |=> (r_state == S_FIN))
        else $error("result left while output register was occupied");

    a_addr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_rd_addr <= r_n))
        else $error("vertex read address beyond vertex count");

    a_few_outside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[0]) |-> (o_m_axis_tdata[0] == 1'b0))
        else $error("inside flagged with too few vertices");

    a_no_read_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rd_vld || r_close) |-> (r_state == S_RUN))
        else $error("vertex read outside a query walk");
`endif

endmodule

@@ rtl/pipr_ram.sv @@
// ----------------------------------------------------------------------------
// pipr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pipr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/pipr_edge.sv @@
// ----------------------------------------------------------------------------
// pipr_edge
// Edge crossing test: differences, exact cross products, signed compare.
// ----------------------------------------------------------------------------
module pipr_edge (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic signed [pipr_pkg::COORD_W-1:0] i_px,
    input  logic signed [pipr_pkg::COORD_W-1:0] i_py,
    input  pipr_pkg::t_edge                    i_edge,
    output pipr_pkg::t_cross                   o_cross
);
    import pipr_pkg::*;

    logic                     r_s1_vld;
    logic                     r_s1_last;
    logic                     r_s1_strad;
    logic                     r_s1_dypos;
    logic signed [DIFF_W-1:0] r_s1_a;
    logic signed [DIFF_W-1:0] r_s1_b;
    logic signed [DIFF_W-1:0] r_s1_c;
    logic signed [DIFF_W-1:0] r_s1_d;

    logic                     r_s2_vld;
    logic                     r_s2_last;
    logic                     r_s2_strad;
    logic                     r_s2_dypos;
    logic signed [PROD_W-1:0] r_s2_p1;
    logic signed [PROD_W-1:0] r_s2_p2;

    logic signed [DIFF_W-1:0] n_s1_d;

    assign n_s1_d = DIFF_W'(i_edge.yj) - DIFF_W'(i_edge.yi);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_edge.vld;
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_last  <= i_edge.last;
        r_s1_strad <= (i_edge.yi > i_py) != (i_edge.yj > i_py);
        r_s1_dypos <= n_s1_d > 0;
        r_s1_a     <= DIFF_W'(i_py) - DIFF_W'(i_edge.yi);
        r_s1_b     <= DIFF_W'(i_edge.xj) - DIFF_W'(i_edge.xi);
        r_s1_c     <= DIFF_W'(i_px) - DIFF_W'(i_edge.xi);
        r_s1_d     <= n_s1_d;

        r_s2_last  <= r_s1_last;
        r_s2_strad <= r_s1_strad;
        r_s2_dypos <= r_s1_dypos;
        r_s2_p1    <= r_s1_a * r_s1_b;
        r_s2_p2    <= r_s1_c * r_s1_d;
    end

    always_comb begin
        o_cross.vld  = r_s2_vld;
        o_cross.last = r_s2_last;
        o_cross.hit  = r_s2_strad &&
                       (r_s2_dypos ? (r_s2_p1 > r_s2_p2) : (r_s2_p1 < r_s2_p2));
    end

endmodule
